FILE: rtl/tvbs_pkg.sv
`timescale 1ns / 1ps
package tvbs_pkg;

    // action codes
    localparam logic [2:0] ACT_BYTE   = 3'd0;
    localparam logic [2:0] ACT_WORD16 = 3'd1;
    localparam logic [2:0] ACT_WORD32 = 3'd2;
    localparam logic [2:0] ACT_WORD64 = 3'd3;
    localparam logic [2:0] ACT_VARINT = 3'd4;
    localparam logic [2:0] ACT_UTF16  = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_CEILING   = 2'd1;
    localparam logic [1:0] ST_SURROGATE = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] value;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last_byte;
        logic [1:0]  status;
        logic [31:0] total_bytes;
    } t_out_word;

    // one classified item waiting for the back end
    typedef struct packed {
        logic [7:0][7:0] bytes;     // bytes[0] goes out first
        logic [2:0]      last_idx;  // index of the final byte
        logic [1:0]      status;
        logic [31:0]     base;      // byte count before this item
    } t_job;

    // queue to back end handshake
    typedef struct packed {
        logic valid;
        t_job job;
    } t_head;

endpackage

FILE: rtl/tvbs_front.sv
`timescale 1ns / 1ps
module tvbs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata,
    input  logic              i_take,
    input  tvbs_pkg::t_in_word i_in_word,
    output logic              o_job_we,
    output tvbs_pkg::t_job    o_job
);
    import tvbs_pkg::*;

    logic [31:0] r_max;
    logic [31:0] r_count;
    logic [31:0] n_count;

    logic [7:0][7:0] w_bytes;
    logic [3:0]      w_len;
    logic            w_known;
    logic            w_surrogate;
    logic            w_ceiling;
    logic [15:0]     w_code;
    logic [31:0]     w_v32;
    logic [34:0]     w_varint;
    logic [31:0]     w_room;
    logic [2:0]      w_groups;
    logic [3:0]      w_len_m1;

    assign w_code = i_in_word.value[15:0];
    assign w_v32  = i_in_word.value[31:0];
    // pad to five full 7-bit groups
    assign w_varint = {3'b000, w_v32};
    assign w_groups = 3'(w_v32 >= 32'h80) + 3'(w_v32 >= 32'h4000)
                    + 3'(w_v32 >= 32'h20_0000) + 3'(w_v32 >= 32'h1000_0000);

    always_comb begin
        w_bytes     = i_in_word.value;
        w_len       = 4'd1;
        w_known     = 1'b1;
        w_surrogate = 1'b0;
        case (i_in_word.action)
            ACT_BYTE:   w_len = 4'd1;
            ACT_WORD16: w_len = 4'd2;
            ACT_WORD32: w_len = 4'd4;
            ACT_WORD64: w_len = 4'd8;
            ACT_VARINT: begin
                w_len = {1'b0, w_groups} + 4'd1;
                for (int i = 0; i < 5; i++) begin
                    w_bytes[i] = {(3'(i) < w_groups), w_varint[7*i +: 7]};
                end
            end
            ACT_UTF16: begin
                w_surrogate = (w_code[15:11] == 5'b11011);
                if (w_code < 16'h0080) begin
                    w_len = 4'd1;
                    w_bytes[0] = w_code[7:0];
                end else if (w_code < 16'h0800) begin
                    w_len = 4'd2;
                    w_bytes[0] = {3'b110, w_code[10:6]};
                    w_bytes[1] = {2'b10, w_code[5:0]};
                end else begin
                    w_len = 4'd3;
                    w_bytes[0] = {4'b1110, w_code[15:12]};
                    w_bytes[1] = {2'b10, w_code[11:6]};
                    w_bytes[2] = {2'b10, w_code[5:0]};
                end
            end
            default: w_known = 1'b0;
        endcase
    end

    assign w_room    = r_max - r_count;
    assign w_ceiling = (r_count > r_max) || ({28'd0, w_len} > w_room);
    assign w_len_m1  = w_len - 4'd1;

    always_comb begin
        o_job.base = r_count;
        if (w_surrogate) begin
            o_job.bytes    = '0;
            o_job.last_idx = '0;
            o_job.status   = ST_SURROGATE;
        end else if (w_ceiling) begin
            o_job.bytes    = '0;
            o_job.last_idx = '0;
            o_job.status   = ST_CEILING;
        end else begin
            o_job.bytes    = w_bytes;
            o_job.last_idx = w_len_m1[2:0];
            o_job.status   = ST_OK;
        end
    end

    assign o_job_we = i_take && w_known;

    always_comb begin
        n_count = r_count;
        if (o_job_we && !w_surrogate && !w_ceiling) begin
            n_count = r_count + {28'd0, w_len};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= 32'hFFFF_FFFF;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
        end
    end

endmodule

FILE: rtl/tvbs_queue.sv
`timescale 1ns / 1ps
module tvbs_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_we,
    input  tvbs_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output tvbs_pkg::t_head o_head
);
    import tvbs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;

    assign o_full      = (r_cnt == CNT_W'(DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.job   = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_we) begin
                r_wr_ptr <= wrap_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= wrap_inc(r_rd_ptr);
            end
            case ({i_we, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/tvbs_back.sv
`timescale 1ns / 1ps
module tvbs_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tvbs_pkg::t_head     i_head,
    output logic                o_head_pop,
    input  logic                i_pop,
    output logic                o_valid,
    output tvbs_pkg::t_out_word o_out_word
);
    import tvbs_pkg::*;

    t_out_word r_out;
    logic      r_valid;
    logic [2:0] r_idx;

    logic      w_load;
    logic      w_last;
    t_out_word w_word;

    assign w_load = i_head.valid && (!r_valid || i_pop);
    assign w_last = (r_idx == i_head.job.last_idx);
    assign o_head_pop = w_load && w_last;

    always_comb begin
        w_word.out_byte  = i_head.job.bytes[r_idx];
        w_word.last_byte = w_last;
        w_word.status    = i_head.job.status;
        if (i_head.job.status == ST_OK) begin
            w_word.total_bytes = i_head.job.base + {29'd0, r_idx} + 32'd1;
        end else begin
            w_word.total_bytes = i_head.job.base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_last ? '0 : r_idx + 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_out_word = r_out;

endmodule

FILE: rtl/typed_value_byte_serializer.sv
`timescale 1ns / 1ps
// Channel   | Direction | Handshake            | Word
// ----------+-----------+----------------------+---------------------------------------
// input     | in        | push / full          | action, value
// result    | out       | empty / pop          | out_byte, last_byte, status, total_bytes
// config    | in        | i_cfg_we             | i_cfg_wdata (max_payload_bytes)
//
// The front end classifies and checks capacity in the accept cycle, so an input word is
// taken every cycle while the job queue has room. The back end sends one byte per cycle
// from the head job while results are popped: an item yields 1 to 8 bytes (its encoded
// length, or one for an error), and that byte-per-cycle loop sets the sustained rate. The
// first byte passes through the job queue and the output register. Reset (synchronous,
// active low) empties the queue, clears the byte count and sets the ceiling to all ones.
// A stalled result holds in the output register while the front keeps filling the queue.
module typed_value_byte_serializer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  tvbs_pkg::t_in_word  i_in_word,
    output logic                empty,
    input  logic                pop,
    output tvbs_pkg::t_out_word o_out_word,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata
);
    import tvbs_pkg::*;

    logic  w_take;
    logic  w_job_we;
    t_job  w_job;
    logic  w_q_full;
    t_head w_head;
    logic  w_head_pop;
    logic  w_out_valid;

    // accept an input word whenever the queue can hold its job
    assign w_take = push && !w_q_full;
    assign full   = w_q_full;

    tvbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (w_take),
        .i_in_word   (i_in_word),
        .o_job_we    (w_job_we),
        .o_job       (w_job)
    );

    // decouple classification from byte emission
    tvbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_job_we),
        .i_job   (w_job),
        .i_pop   (w_head_pop),
        .o_full  (w_q_full),
        .o_head  (w_head)
    );

    // walk the head job one byte a cycle into the output register while it is free or popped
    tvbs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .o_head_pop (w_head_pop),
        .i_pop      (pop),
        .o_valid    (w_out_valid),
        .o_out_word (o_out_word)
    );

    assign empty = !w_out_valid;

endmodule
